[design/lic_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the line intersection classifier
// no dependencies
package lic_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [1:0] {
        REL_INTERSECT = 2'd0,
        REL_OVERLAP   = 2'd1,
        REL_APART     = 2'd2,
        REL_PARALLEL  = 2'd3
    } t_relation;

    function automatic int eff_width(input int cw);
        return (cw < 16) ? cw : 16;
    endfunction

endpackage

[design/lic_front.sv]
`timescale 1ns / 1ps
// front end: products, cross terms and relation class of each item
// depends on lic_pkg
module lic_front
    import lic_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [15:0]                   i_ax,
    input  logic [15:0]                   i_ay,
    input  logic [15:0]                   i_bx,
    input  logic [15:0]                   i_by,
    input  logic [15:0]                   i_cx,
    input  logic [15:0]                   i_cy,
    input  logic [15:0]                   i_dx,
    input  logic [15:0]                   i_dy,
    output logic                          o_push,
    output t_relation                     o_rel,
    output logic signed [2*eff_width(COORD_WIDTH):0]   o_cr,
    output logic signed [2*eff_width(COORD_WIDTH)+1:0] o_tn,
    output logic signed [2*eff_width(COORD_WIDTH)+1:0] o_sn
);

    localparam int EW = eff_width(COORD_WIDTH);

    logic signed [EW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic signed [EW:0]   wx, wy;
    logic signed [EW:0]   p0, p1, r0, r1, plo, phi, rlo, rhi;
    logic                 n_ov;

    logic signed [2*EW-1:0] n_p1, n_p2;
    logic signed [2*EW:0]   n_p3, n_p4, n_p5, n_p6;

    logic                   r1_v;
    logic signed [2*EW-1:0] r1_p1, r1_p2;
    logic signed [2*EW:0]   r1_p3, r1_p4, r1_p5, r1_p6;
    logic                   r1_ov;

    logic                   r2_v;
    t_relation              r2_rel, n_rel;
    logic signed [2*EW:0]   r2_cr, n_cr;
    logic signed [2*EW+1:0] r2_tn, n_tn, r2_sn, n_sn;

    assign ax = $signed(i_ax[EW-1:0]);
    assign ay = $signed(i_ay[EW-1:0]);
    assign bx = $signed(i_bx[EW-1:0]);
    assign by = $signed(i_by[EW-1:0]);
    assign cx = $signed(i_cx[EW-1:0]);
    assign cy = $signed(i_cy[EW-1:0]);
    assign dx = $signed(i_dx[EW-1:0]);
    assign dy = $signed(i_dy[EW-1:0]);

    assign wx = {ax[EW-1], ax} - {cx[EW-1], cx};
    assign wy = {ay[EW-1], ay} - {cy[EW-1], cy};

    assign n_p1 = bx * dy;
    assign n_p2 = by * dx;
    assign n_p3 = wx * dy;
    assign n_p4 = wy * dx;
    assign n_p5 = wy * bx;
    assign n_p6 = wx * by;

    // span ends along y when the first direction has no x part
    always_comb begin
        if (bx == '0) begin
            p0 = {ay[EW-1], ay};
            p1 = {ay[EW-1], ay} + {by[EW-1], by};
            r0 = {cy[EW-1], cy};
            r1 = {cy[EW-1], cy} + {dy[EW-1], dy};
        end else begin
            p0 = {ax[EW-1], ax};
            p1 = {ax[EW-1], ax} + {bx[EW-1], bx};
            r0 = {cx[EW-1], cx};
            r1 = {cx[EW-1], cx} + {dx[EW-1], dx};
        end
        plo  = (p0 < p1) ? p0 : p1;
        phi  = (p0 > p1) ? p0 : p1;
        rlo  = (r0 < r1) ? r0 : r1;
        rhi  = (r0 > r1) ? r0 : r1;
        n_ov = !(rlo > phi) && !(rhi < plo);
    end

    always_comb begin
        n_cr = {r1_p1[2*EW-1], r1_p1} - {r1_p2[2*EW-1], r1_p2};
        n_tn = {r1_p3[2*EW], r1_p3} - {r1_p4[2*EW], r1_p4};
        n_sn = {r1_p5[2*EW], r1_p5} - {r1_p6[2*EW], r1_p6};
        if (n_cr != '0) begin
            n_rel = REL_INTERSECT;
        end else if (n_tn != '0) begin
            n_rel = REL_PARALLEL;
        end else if (r1_ov) begin
            n_rel = REL_OVERLAP;
        end else begin
            n_rel = REL_APART;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p1  <= n_p1;
            r1_p2  <= n_p2;
            r1_p3  <= n_p3;
            r1_p4  <= n_p4;
            r1_p5  <= n_p5;
            r1_p6  <= n_p6;
            r1_ov  <= n_ov;
            r2_cr  <= n_cr;
            r2_tn  <= n_tn;
            r2_sn  <= n_sn;
            r2_rel <= n_rel;
        end
    end

    assign o_push = i_en && r2_v;
    assign o_rel  = r2_rel;
    assign o_cr   = r2_cr;
    assign o_tn   = r2_tn;
    assign o_sn   = r2_sn;

endmodule

[design/lic_queue.sv]
`timescale 1ns / 1ps
// short item queue between front end and divider back end
// depends on lic_pkg
module lic_queue
    import lic_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

endmodule

[design/lic_back.sv]
`timescale 1ns / 1ps
// back end: pipelined restoring division of t and s, saturation, output register
// depends on lic_pkg
module lic_back
    import lic_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  t_relation                     i_rel,
    input  logic signed [2*eff_width(COORD_WIDTH):0]   i_cr,
    input  logic signed [2*eff_width(COORD_WIDTH)+1:0] i_tn,
    input  logic signed [2*eff_width(COORD_WIDTH)+1:0] i_sn,
    output logic                          o_pop,
    input  logic                          i_stall,
    output logic                          o_valid,
    output t_relation                     o_rel,
    output logic signed [31:0]            o_t,
    output logic signed [31:0]            o_s,
    output logic                          o_sat
);

    localparam int EW = eff_width(COORD_WIDTH);
    localparam int DW = 2 * EW + 1;
    localparam int NW = 2 * EW + 2;
    localparam int NQ = NW + FRAC_BITS;
    localparam int QX = (NQ > 32) ? NQ : 33;
    localparam logic [QX-1:0] LIM_POS = QX'(33'h07fffffff);
    localparam logic [QX-1:0] LIM_NEG = QX'(33'h080000000);

    logic b_en;

    logic            r_v     [NQ+1];
    t_relation       r_rel   [NQ+1];
    logic            r_neg_t [NQ+1];
    logic            r_neg_s [NQ+1];
    logic [DW-1:0]   r_den   [NQ+1];
    logic [DW-1:0]   r_rem_t [NQ+1];
    logic [DW-1:0]   r_rem_s [NQ+1];
    logic [NQ-1:0]   r_dvd_t [NQ+1];
    logic [NQ-1:0]   r_dvd_s [NQ+1];
    logic [NQ-1:0]   r_q_t   [NQ+1];
    logic [NQ-1:0]   r_q_s   [NQ+1];

    logic [DW-1:0]   n_rem_t [NQ];
    logic [DW-1:0]   n_rem_s [NQ];
    logic            n_bit_t [NQ];
    logic            n_bit_s [NQ];

    logic [NW-1:0]   mag_t, mag_s;
    logic [DW-1:0]   mag_d;

    logic [QX-1:0]   qx_t, qx_s;
    logic            sat_t, sat_s;
    logic [31:0]     n_t, n_s;

    logic            r_o_valid, r_o_sat;
    t_relation       r_o_rel;
    logic [31:0]     r_o_t, r_o_s;

    function automatic logic [DW:0] div_step(
        input logic [DW-1:0] rem,
        input logic          nb,
        input logic [DW-1:0] den
    );
        logic [DW:0] tr;
        logic [DW:0] df;
        tr = {rem, nb};
        df = tr - {1'b0, den};
        if (tr >= {1'b0, den}) begin
            return {1'b1, df[DW-1:0]};
        end
        return {1'b0, tr[DW-1:0]};
    endfunction

    assign b_en  = !(r_o_valid && i_stall);
    assign o_pop = b_en && i_valid;

    assign mag_t = i_tn[NW-1] ? NW'(-i_tn) : NW'(i_tn);
    assign mag_s = i_sn[NW-1] ? NW'(-i_sn) : NW'(i_sn);
    assign mag_d = i_cr[DW-1] ? DW'(-i_cr) : DW'(i_cr);

    always_comb begin
        for (int k = 0; k < NQ; k++) begin
            {n_bit_t[k], n_rem_t[k]} = div_step(r_rem_t[k], r_dvd_t[k][NQ-1], r_den[k]);
            {n_bit_s[k], n_rem_s[k]} = div_step(r_rem_s[k], r_dvd_s[k][NQ-1], r_den[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NQ; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (b_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < NQ; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_rel[0]   <= i_rel;
            r_neg_t[0] <= (i_tn[NW-1]) != (i_cr != '0 && !i_cr[DW-1]);
            r_neg_s[0] <= (i_sn[NW-1]) != i_cr[DW-1];
            r_den[0]   <= mag_d;
            r_rem_t[0] <= '0;
            r_rem_s[0] <= '0;
            r_dvd_t[0] <= NQ'(mag_t) << FRAC_BITS;
            r_dvd_s[0] <= NQ'(mag_s) << FRAC_BITS;
            r_q_t[0]   <= '0;
            r_q_s[0]   <= '0;
            for (int k = 0; k < NQ; k++) begin
                r_rel[k+1]   <= r_rel[k];
                r_neg_t[k+1] <= r_neg_t[k];
                r_neg_s[k+1] <= r_neg_s[k];
                r_den[k+1]   <= r_den[k];
                r_rem_t[k+1] <= n_rem_t[k];
                r_rem_s[k+1] <= n_rem_s[k];
                r_dvd_t[k+1] <= r_dvd_t[k] << 1;
                r_dvd_s[k+1] <= r_dvd_s[k] << 1;
                r_q_t[k+1]   <= {r_q_t[k][NQ-2:0], n_bit_t[k]};
                r_q_s[k+1]   <= {r_q_s[k][NQ-2:0], n_bit_s[k]};
            end
        end
    end

    // sign, clip to 32 bits, zero for parallel classes
    always_comb begin
        qx_t  = QX'(r_q_t[NQ]);
        qx_s  = QX'(r_q_s[NQ]);
        sat_t = r_neg_t[NQ] ? (qx_t > LIM_NEG) : (qx_t > LIM_POS);
        sat_s = r_neg_s[NQ] ? (qx_s > LIM_NEG) : (qx_s > LIM_POS);
        if (sat_t) begin
            n_t = r_neg_t[NQ] ? 32'h80000000 : 32'h7fffffff;
        end else begin
            n_t = r_neg_t[NQ] ? -qx_t[31:0] : qx_t[31:0];
        end
        if (sat_s) begin
            n_s = r_neg_s[NQ] ? 32'h80000000 : 32'h7fffffff;
        end else begin
            n_s = r_neg_s[NQ] ? -qx_s[31:0] : qx_s[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_en) begin
            r_o_valid <= r_v[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_o_rel <= r_rel[NQ];
            if (r_rel[NQ] == REL_INTERSECT) begin
                r_o_t   <= n_t;
                r_o_s   <= n_s;
                r_o_sat <= sat_t || sat_s;
            end else begin
                r_o_t   <= '0;
                r_o_s   <= '0;
                r_o_sat <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_rel   = r_o_rel;
    assign o_t     = r_o_t;
    assign o_s     = r_o_s;
    assign o_sat   = r_o_sat;

`ifndef SYNTHESIS
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_rel != REL_INTERSECT |-> r_o_t == '0 && r_o_s == '0 && !r_o_sat)
        else $error("parallel item with nonzero parameters");
    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_sat |-> r_o_t == 32'h7fffffff || r_o_t == 32'h80000000 ||
            r_o_s == 32'h7fffffff || r_o_s == 32'h80000000)
        else $error("saturation flag without clipped parameter");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_valid)
        else $error("pop from empty queue");
    a_last_stage_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NQ] && b_en |=> r_o_valid)
        else $error("divider item lost at output");
`endif

endmodule

[design/line_intersection_classify_2d.sv]
`timescale 1ns / 1ps
// an accepted item passes the front end registers, the queue, the divider pipeline
// (one quotient bit per stage) and the output register before it shows on o_valid
// throughput: one item per cycle, held back only by i_stall at the output
// reset: synchronous, active low, clears valid bits and queue pointers
// depends on lic_pkg, lic_front, lic_queue, lic_back
module line_intersection_classify_2d
    import lic_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_first_origin_x,
    input  logic signed [15:0] i_first_origin_y,
    input  logic signed [15:0] i_first_dir_x,
    input  logic signed [15:0] i_first_dir_y,
    input  logic signed [15:0] i_second_origin_x,
    input  logic signed [15:0] i_second_origin_y,
    input  logic signed [15:0] i_second_dir_x,
    input  logic signed [15:0] i_second_dir_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_relation,
    output logic signed [31:0] o_first_param,
    output logic signed [31:0] o_second_param,
    output logic               o_param_saturated
);

    localparam int EW = eff_width(COORD_WIDTH);
    localparam int DW = 2 * EW + 1;
    localparam int NW = 2 * EW + 2;
    localparam int QW = 2 + DW + 2 * NW;

    logic               f_en, push, pop, q_full, q_empty;
    t_relation          f_rel, q_rel, b_rel;
    logic signed [DW-1:0] f_cr, q_cr;
    logic signed [NW-1:0] f_tn, f_sn, q_tn, q_sn;
    logic [QW-1:0]      q_out;

    assign f_en    = !q_full || pop;
    assign o_stall = !f_en;

    lic_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (f_en),
        .i_valid (i_valid),
        .i_ax    (i_first_origin_x),
        .i_ay    (i_first_origin_y),
        .i_bx    (i_first_dir_x),
        .i_by    (i_first_dir_y),
        .i_cx    (i_second_origin_x),
        .i_cy    (i_second_origin_y),
        .i_dx    (i_second_dir_x),
        .i_dy    (i_second_dir_y),
        .o_push  (push),
        .o_rel   (f_rel),
        .o_cr    (f_cr),
        .o_tn    (f_tn),
        .o_sn    (f_sn)
    );

    lic_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_rel, f_cr, f_tn, f_sn}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    assign q_rel = t_relation'(q_out[QW-1 -: 2]);
    assign q_cr  = q_out[2*NW +: DW];
    assign q_tn  = q_out[NW +: NW];
    assign q_sn  = q_out[0 +: NW];

    lic_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .i_rel   (q_rel),
        .i_cr    (q_cr),
        .i_tn    (q_tn),
        .i_sn    (q_sn),
        .o_pop   (pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_rel   (b_rel),
        .o_t     (o_first_param),
        .o_s     (o_second_param),
        .o_sat   (o_param_saturated)
    );

    assign o_relation = b_rel;

endmodule

[verif/line_intersection_classify_2d_test.sv]
`timescale 1ns / 1ps
// testbench of line_intersection_classify_2d: random and corner line pairs, scoreboard check
// depends on lic_pkg and the block under test
module line_intersection_classify_2d_test;
    import lic_pkg::*;

    typedef struct packed {
        logic signed [15:0] ax, ay, bx, by, cx, cy, dx, dy;
    } t_pair;

    typedef struct packed {
        t_relation          rel;
        logic signed [31:0] t;
        logic signed [31:0] s;
        logic               sat;
    } t_answer;

    localparam int LATENCY  = 2 * 16 + 16 + 6;
    localparam int WD_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    t_pair cur = '0;
    logic [1:0] o_relation;
    logic signed [31:0] o_first_param, o_second_param;
    logic o_param_saturated;

    t_pair   pending[$];
    t_answer answers[$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      gap = 0;
    int      hold = 0;
    int      drain_req = 0;
    bit      long_hold_done = 0;
    bit      in_acc = 0;
    int      sent = 0;

    always #1 i_clk = ~i_clk;

    line_intersection_classify_2d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_first_origin_x(cur.ax), .i_first_origin_y(cur.ay),
        .i_first_dir_x(cur.bx), .i_first_dir_y(cur.by),
        .i_second_origin_x(cur.cx), .i_second_origin_y(cur.cy),
        .i_second_dir_x(cur.dx), .i_second_dir_y(cur.dy),
        .o_valid(o_valid), .i_stall(i_stall), .o_relation(o_relation),
        .o_first_param(o_first_param), .o_second_param(o_second_param),
        .o_param_saturated(o_param_saturated)
    );

    function automatic logic [31:0] fixed_quotient(input longint num, input longint den,
                                                   inout logic sat);
        longint unsigned q;
        longint unsigned mn;
        longint unsigned md;
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        q = (mn << 16) / md;
        if ((num < 0) != (den < 0)) begin
            if (q > 64'h8000_0000) begin
                q = 64'h8000_0000;
                sat = 1'b1;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF) begin
            q = 64'h7FFF_FFFF;
            sat = 1'b1;
        end
        return 32'(q);
    endfunction

    function automatic bit spans_touch(input longint p0, p1, r0, r1);
        longint plo, phi, rlo, rhi;
        plo = (p0 < p1) ? p0 : p1;
        phi = (p0 > p1) ? p0 : p1;
        rlo = (r0 < r1) ? r0 : r1;
        rhi = (r0 > r1) ? r0 : r1;
        return !(rlo > phi || rhi < plo);
    endfunction

    function automatic t_answer classify_pair(input t_pair p);
        t_answer r;
        longint ax, ay, bx, by, cx, cy, dx, dy, cr, wx, wy;
        logic sat;
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
        cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
        cr = bx * dy - by * dx;
        r = '0;
        sat = 1'b0;
        if (cr == 0) begin
            if ((cx - ax) * dy - (cy - ay) * dx != 0) r.rel = REL_PARALLEL;
            else if (bx == 0)
                r.rel = spans_touch(ay, ay + by, cy, cy + dy) ? REL_OVERLAP : REL_APART;
            else
                r.rel = spans_touch(ax, ax + bx, cx, cx + dx) ? REL_OVERLAP : REL_APART;
        end else begin
            wx = ax - cx;
            wy = ay - cy;
            r.rel = REL_INTERSECT;
            r.t = fixed_quotient(wx * dy - wy * dx, dx * by - dy * bx, sat);
            r.s = fixed_quotient(wy * bx - wx * by, cr, sat);
            r.sat = sat;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        int k, m;
        p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        case ($urandom_range(0, 5))
            0: begin
                // parallel: second direction a multiple of the first
                k = int'($urandom_range(0, 6)) - 3;
                p.bx = 16'(int'($urandom_range(0, 200)) - 100);
                p.by = 16'(int'($urandom_range(0, 200)) - 100);
                p.dx = 16'(k * p.bx);
                p.dy = 16'(k * p.by);
                if ($urandom_range(0, 1)) begin
                    m = int'($urandom_range(0, 8)) - 4;
                    p.cx = 16'(p.ax + m * p.bx);
                    p.cy = 16'(p.ay + m * p.by);
                end
            end
            1: begin
                p.bx = 16'(int'($urandom_range(0, 20)) - 10);
                p.by = 16'(int'($urandom_range(0, 20)) - 10);
                p.dx = 16'(int'($urandom_range(0, 20)) - 10);
                p.dy = 16'(int'($urandom_range(0, 20)) - 10);
                p.cx = 16'(p.ax + int'($urandom_range(0, 40)) - 20);
                p.cy = 16'(p.ay + int'($urandom_range(0, 40)) - 20);
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 80);
        if ($urandom_range(0, 1)) return 0;
        return $urandom_range(0, 3);
    endfunction

    // driver, in_acc tells whether the item on the port was taken at the last rising edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !in_acc) begin
            end else if (drain_req == 1 && answers.size() != 0) begin
                i_valid <= 1'b0;
            end else if (gap > 0) begin
                gap <= gap - 1;
                i_valid <= 1'b0;
            end else if (pending.size() != 0) begin
                if (drain_req == 1) drain_req <= 2;
                cur <= pending.pop_front();
                i_valid <= 1'b1;
                gap <= rand_gap();
            end else begin
                i_valid <= 1'b0;
            end
            if (drain_req == 0 && sent >= 1000) drain_req <= 1;
        end
    end

    // receiver stall and monitor
    always @(negedge i_clk) begin
        if (!long_hold_done && sent >= 300) begin
            long_hold_done <= 1;
            hold <= 200;
            i_stall <= 1'b1;
        end else if (hold > 0) begin
            hold <= hold - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 39) == 0) begin
            hold <= $urandom_range(5, 60);
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        in_acc <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (answers.size() == 0) begin
                    report_mismatch("result with no item waiting", 1, 0);
                end else begin
                    want = answers.pop_front();
                    if (o_relation !== want.rel) report_mismatch("relation", o_relation, want.rel);
                    if (o_first_param !== want.t) report_mismatch("t", o_first_param, want.t);
                    if (o_second_param !== want.s) report_mismatch("s", o_second_param, want.s);
                    if (o_param_saturated !== want.sat)
                        report_mismatch("saturated", o_param_saturated, want.sat);
                end
            end
            if (i_valid && !o_stall) begin
                answers.push_back(classify_pair(cur));
                sent++;
            end
            if (idle_cycles >= WD_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        t_pair p;
        // directed: extremes, intersect, saturation, parallel, collinear, zero directions
        pending.push_back('0);
        pending.push_back({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1});
        pending.push_back({16'sd0, 16'sd0, 16'sd2, 16'sd2, 16'sd0, 16'sd2, 16'sd2, -16'sd2});
        pending.push_back({16'h7FFF, 16'h7FFF, 16'sd1, 16'sd0, 16'h8000, 16'h8000, 16'sd0, 16'sd1});
        pending.push_back({16'h8000, 16'h8000, 16'sd1, 16'sd0, 16'h7FFF, 16'h7FFF, 16'sd0, 16'sd1});
        pending.push_back({16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                           16'h7FFF, 16'h7FFF});
        pending.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                           16'h8000, 16'h7FFF});
        pending.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           16'hFFFF, 16'hFFFE});
        pending.push_back({16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd1, 16'sd2, 16'sd2});
        pending.push_back({16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd2, 16'sd0, 16'sd4, 16'sd0});
        pending.push_back({16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd4, 16'sd0, 16'sd1, 16'sd0});
        pending.push_back({16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd5, 16'sd0, 16'sd1, 16'sd0});
        pending.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd3, 16'sd0, 16'sd2});
        pending.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd4, 16'sd0, -16'sd0});
        pending.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd7, 16'sd0, 16'sd0});
        pending.push_back({16'sd0, 16'sd0, 16'sd0, -16'sd3, 16'sd0, -16'sd9, 16'sd0, 16'sd5});
        pending.push_back({16'sd1, 16'sd2, 16'sd3, 16'sd0, 16'sd9, 16'sd9, 16'sd0, 16'sd0});
        pending.push_back({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd1});
        for (int i = 0; i < 2000; i++) begin
            p = rand_pair();
            pending.push_back(p);
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending.size() == 0 && !i_valid);
        wait (answers.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && answers.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
